// ----- rtl/dpt_pkg.sv -----
// Shared types and constants for the detection persistence tracker.
`timescale 1ns / 1ps
`default_nettype none

package dpt_pkg;

	localparam int COORD_W  = 13;
	localparam int HITS_W   = 16;
	localparam int TIME_W   = 32;
	localparam int THR_W    = 8;
	localparam int TOUT_W   = 16;
	localparam int SQ_W     = 2 * COORD_W;
	localparam int D2_W     = SQ_W + 1;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam int IN_DAT_W  = 64;
	localparam int OUT_DAT_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_FRAMES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_RADIUS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TRACK_TIMEOUT  = 2'd2;

	localparam logic [THR_W-1:0]   CONFIRM_RESET = 8'd3;
	localparam logic [COORD_W-1:0] RADIUS_RESET  = 13'd120;
	localparam logic [TOUT_W-1:0]  TIMEOUT_RESET = 16'd500;

	localparam logic [HITS_W-1:0]  HITS_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AGE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} dpt_state_t;

	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [HITS_W-1:0]  hits;
	} dpt_track_t;

	typedef struct packed {
		logic              valid;
		logic              win;
		logic [D2_W-1:0]   d2;
		logic [HITS_W-1:0] hits;
	} dpt_cand_t;

endpackage

`default_nettype wire

// ----- rtl/dpt_track_mem.sv -----
// Two-bank track store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module dpt_track_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  wire logic                clk,
	input  wire logic                we,
	input  wire logic [AW-1:0]       waddr,
	input  wire dpt_pkg::dpt_track_t wdata,
	input  wire logic [AW-1:0]       raddr,
	output dpt_pkg::dpt_track_t      rdata
);
	import dpt_pkg::*;

	dpt_track_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/dpt_dist_unit.sv -----
// Shared distance unit: squares registered, then sum and best-candidate compare.
`timescale 1ns / 1ps
`default_nettype none

module dpt_dist_unit #(
	parameter int SW = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	input  wire logic [dpt_pkg::COORD_W-1:0]  cx,
	input  wire logic [dpt_pkg::COORD_W-1:0]  cy,
	input  wire dpt_pkg::dpt_track_t          trk,
	input  wire logic [SW-1:0]                in_slot,
	input  wire logic [dpt_pkg::SQ_W-1:0]     r2,
	input  wire logic                         best_found,
	input  wire logic [dpt_pkg::D2_W-1:0]     best_d,
	output dpt_pkg::dpt_cand_t                cand,
	output logic [SW-1:0]                     cand_slot
);
	import dpt_pkg::*;

	logic signed [COORD_W:0]     dx, dy;
	logic signed [2*COORD_W+1:0] px, py;
	logic                        valid_s2;
	logic [SQ_W-1:0]             sqx_s2, sqy_s2;
	logic [HITS_W-1:0]           hits_s2;
	logic [SW-1:0]               slot_s2;
	logic [D2_W-1:0]             d2;

	assign dx = $signed({1'b0, cx}) - $signed({1'b0, trk.col});
	assign dy = $signed({1'b0, cy}) - $signed({1'b0, trk.row});
	assign px = (2*COORD_W+2)'(dx) * (2*COORD_W+2)'(dx);
	assign py = (2*COORD_W+2)'(dy) * (2*COORD_W+2)'(dy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s2  <= px[SQ_W-1:0];
		sqy_s2  <= py[SQ_W-1:0];
		hits_s2 <= trk.hits;
		slot_s2 <= in_slot;
	end

	assign d2 = D2_W'(sqx_s2) + D2_W'(sqy_s2);

	// strict less-than keeps the earlier slot on a tie
	always_comb begin
		cand.valid = valid_s2;
		cand.win   = valid_s2 && (d2 <= D2_W'(r2)) && (!best_found || d2 < best_d);
		cand.d2    = d2;
		cand.hits  = hits_s2;
		cand_slot  = slot_s2;
	end

endmodule

`default_nettype wire

// ----- rtl/detection_persistence_tracker_core.sv -----
// Top level: sequencer, bank bookkeeping, config registers and result register.
//
// Channel  | Dir | Handshake          | Word
// ---------+-----+--------------------+---------------------------------------------
// s_       | in  | s_tvalid/s_tready  | detection: tdata, tuser=has_detection, tlast
// m_       | out | m_tvalid/m_tready  | result word in m_tdata[23:0]
// cfg_     | in  | cfg_we             | register write, no read-back
//
// Steps: after a detection word is accepted, an age check, then one slot per cycle
//   through the shared distance unit (memory read, square, compare), a drain until
//   the unit is empty, and one write-back before the next word is taken.
// A word without detection is taken while idle and gives no result.
// Reset clears bank fills, bank times, taken flags and bank select; config goes to defaults.
// A finished result waits in the output register; the next word is still taken,
// and write-back only stalls when the output register is still occupied.
`timescale 1ns / 1ps
`default_nettype none

module detection_persistence_tracker_core #(
	parameter int MAX_TRACKS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// s_tdata: centre_x[12:0], centre_y[25:13], frame_time[57:26], zero above
	input  wire logic [dpt_pkg::IN_DAT_W-1:0]    s_tdata,
	// s_tuser: has_detection
	input  wire logic                            s_tuser,
	input  wire logic                            s_tlast,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// m_tdata: hit_count[15:0], confirmed[16], newly[17], matched[18],
	//          matched_slot[22:19], not_stored[23]
	output logic [dpt_pkg::OUT_DAT_W-1:0]        m_tdata,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	input  wire logic                            cfg_we,
	input  wire logic [dpt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [dpt_pkg::CFG_DAT_W-1:0]   cfg_data
);
	import dpt_pkg::*;

	localparam int SW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
	localparam int FW = $clog2(MAX_TRACKS + 1);
	localparam int AW = $clog2(2 * MAX_TRACKS);

	// config
	logic [THR_W-1:0]   confirm_q;
	logic [COORD_W-1:0] radius_q;
	logic [TOUT_W-1:0]  timeout_q;
	logic [SQ_W-1:0]    r2_q;

	// bank bookkeeping
	logic                  active_bank_q;
	logic [FW-1:0]         bank_fill_q [2];
	logic [TIME_W-1:0]     bank_time_q [2];
	logic [MAX_TRACKS-1:0] slot_taken_q;

	// current word
	logic [COORD_W-1:0] cx_q, cy_q;
	logic [TIME_W-1:0]  now_q;
	logic               fend_q;

	// scan control and best candidate
	dpt_state_t        state_q, state_d;
	logic [FW-1:0]     scan_q;
	logic              too_old_q;
	logic              valid_s1_q;
	logic [SW-1:0]     slot_s1_q;
	logic              found_q;
	logic [SW-1:0]     best_slot_q;
	logic [D2_W-1:0]   best_d_q;
	logic [HITS_W-1:0] best_hits_q;

	// output register
	logic                 out_valid_q;
	logic [OUT_DAT_W-1:0] out_data_q;

	// control strobes
	logic s_accept, issue, finish_go, do_end;

	logic [FW-1:0]      ofill, nfill;
	logic               full;
	logic [AW-1:0]      raddr, waddr;
	dpt_track_t         rdata, wdata;
	dpt_cand_t          cand;
	logic [SW-1:0]      cand_slot;
	logic [HITS_W-1:0]  count;
	logic [THR_W-1:0]   thr;
	logic               confirmed, newly;

	assign ofill = bank_fill_q[active_bank_q];
	assign nfill = bank_fill_q[~active_bank_q];
	assign full  = (nfill == FW'(MAX_TRACKS));

	// ---- sequencer ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		issue     = 1'b0;
		finish_go = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && s_tuser) begin
					state_d = ST_AGE;
				end
			end
			ST_AGE: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				issue = (scan_q < ofill);
				if ((FW + 1)'(scan_q) + (FW + 1)'(1) >= (FW + 1)'(ofill)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!valid_s1_q && !cand.valid) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || m_tready) begin
					finish_go = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign s_accept = s_tvalid && s_tready;
	// frame boundary: empty end word, or last detection of the frame written back
	assign do_end   = (s_accept && !s_tuser && s_tlast) || (finish_go && fend_q);

	// ---- config registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			confirm_q <= CONFIRM_RESET;
			radius_q  <= RADIUS_RESET;
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CONFIRM_FRAMES: confirm_q <= cfg_data[THR_W-1:0];
				REG_MATCH_RADIUS:   radius_q  <= cfg_data[COORD_W-1:0];
				REG_TRACK_TIMEOUT:  timeout_q <= cfg_data[TOUT_W-1:0];
				default: ;
			endcase
		end
	end

	// squared radius, ready long before the first compare
	always_ff @(posedge clk) begin
		r2_q <= SQ_W'(radius_q) * SQ_W'(radius_q);
	end

	// ---- word capture ----
	always_ff @(posedge clk) begin
		if (s_accept && s_tuser) begin
			cx_q   <= s_tdata[12:0];
			cy_q   <= s_tdata[25:13];
			now_q  <= s_tdata[57:26];
			fend_q <= s_tlast;
		end
	end

	// ---- scan control ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q     <= '0;
			too_old_q  <= 1'b0;
			valid_s1_q <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			valid_s1_q <= issue && !slot_taken_q[scan_q[SW-1:0]] && !too_old_q;
			if (s_accept) begin
				scan_q  <= '0;
				found_q <= 1'b0;
			end else begin
				if (issue) begin
					scan_q <= scan_q + FW'(1);
				end
				if (cand.win) begin
					found_q <= 1'b1;
				end
			end
			if (state_q == ST_AGE) begin
				// age wraps modulo 2^32; a later bank time reads as very old
				too_old_q <= (now_q - bank_time_q[active_bank_q]) > TIME_W'(timeout_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		slot_s1_q <= scan_q[SW-1:0];
		if (cand.win) begin
			best_slot_q <= cand_slot;
			best_d_q    <= cand.d2;
			best_hits_q <= cand.hits;
		end
	end

	assign raddr = active_bank_q ? AW'(MAX_TRACKS) + AW'(scan_q) : AW'(scan_q);

	dpt_track_mem #(
		.DEPTH (2 * MAX_TRACKS),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (finish_go && !full),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	dpt_dist_unit #(
		.SW (SW)
	) u_dist (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (valid_s1_q),
		.cx         (cx_q),
		.cy         (cy_q),
		.trk        (rdata),
		.in_slot    (slot_s1_q),
		.r2         (r2_q),
		.best_found (found_q),
		.best_d     (best_d_q),
		.cand       (cand),
		.cand_slot  (cand_slot)
	);

	// ---- write-back and result ----
	always_comb begin
		if (found_q) begin
			count = (best_hits_q == HITS_MAX) ? best_hits_q : best_hits_q + HITS_W'(1);
		end else begin
			count = HITS_W'(1);
		end
		thr       = (confirm_q == '0) ? THR_W'(1) : confirm_q;
		confirmed = count >= HITS_W'(thr);
		newly     = count == HITS_W'(thr);
		wdata.col  = cx_q;
		wdata.row  = cy_q;
		wdata.hits = count;
	end

	// new tracks go to the spare bank
	assign waddr = (!active_bank_q) ? AW'(MAX_TRACKS) + AW'(nfill) : AW'(nfill);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_bank_q  <= 1'b0;
			bank_fill_q[0] <= '0;
			bank_fill_q[1] <= '0;
			bank_time_q[0] <= '0;
			bank_time_q[1] <= '0;
			slot_taken_q   <= '0;
		end else begin
			if (finish_go) begin
				if (!full) begin
					bank_fill_q[~active_bank_q] <= nfill + FW'(1);
					bank_time_q[~active_bank_q] <= now_q;
				end
			end
			// frame end drops all taken marks, else mark the matched slot
			if (do_end) begin
				slot_taken_q <= '0;
			end else if (finish_go && found_q) begin
				slot_taken_q[best_slot_q] <= 1'b1;
			end
			if (do_end) begin
				active_bank_q                <= ~active_bank_q;
				bank_fill_q[active_bank_q]   <= '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_go) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go) begin
			out_data_q <= {full,
				(found_q ? 4'(best_slot_q) : 4'd0),
				found_q, newly, confirmed, count};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire
